>>> rtl/rsmp_pkg.sv
`timescale 1ns / 1ps

package rsmp_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int SAMPLE_W        = 16;
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int STEP_W          = 20;
    localparam int GAIN_W          = 16;
    localparam int GAIN_SHIFT      = 15;
    localparam int CFG_DATA_W      = STEP_W;
    localparam int CFG_IDX_W       = 2;

    // phase must hold anything below 1.0 plus one full step
    localparam int PHASE_W = ((STEP_W > PHASE_FRAC_BITS) ? STEP_W : PHASE_FRAC_BITS) + 1;
    localparam int SUM_W   = PHASE_W + 1;
    localparam int MUL1_W  = DIFF_W + PHASE_FRAC_BITS + 1;
    localparam int MUL2_W  = DIFF_W + GAIN_W + 1;

    localparam logic [SUM_W-1:0]  ONE_PHASE = {{(SUM_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
    localparam logic [SUM_W-1:0]  TWO_PHASE = ONE_PHASE << 1;
    localparam logic [STEP_W-1:0] MIN_STEP  =
        {{(STEP_W-1){1'b0}}, 1'b1} << (PHASE_FRAC_BITS - 4);

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO       = 2'd2;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = STEP_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_RESET       = GAIN_W'(32768);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [GAIN_W-1:0] gain;
        logic              mono;
    } rsmp_cfg_t;

    // one source frame, classified: interpolation span a -> a+d, held frame c
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a_left;
        logic signed [SAMPLE_W-1:0] a_right;
        logic signed [DIFF_W-1:0]   d_left;
        logic signed [DIFF_W-1:0]   d_right;
        logic signed [SAMPLE_W-1:0] c_left;
        logic signed [SAMPLE_W-1:0] c_right;
        logic                       do_interp;
        logic                       is_end;
    } rsmp_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rsmp_queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_INTERP,
        BK_HOLD
    } rsmp_back_state_t;

endpackage

>>> rtl/rsmp_front.sv
`timescale 1ns / 1ps

module rsmp_front
    import rsmp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic                       stream_end,
    input  logic                       mono,
    input  rsmp_queue_status_t         q_status,
    output logic                       q_push,
    output rsmp_job_t                  job
);

    logic signed [SAMPLE_W-1:0] prev_left_reg;
    logic signed [SAMPLE_W-1:0] prev_right_reg;
    logic                       prev_valid_reg;
    logic                       in_xfer;
    logic signed [SAMPLE_W-1:0] cur_right;
    logic signed [SAMPLE_W-1:0] prv_right;

    assign in_ready = !q_status.full;
    assign in_xfer  = in_valid && in_ready;

    assign cur_right = mono ? left_in : right_in;
    assign prv_right = mono ? prev_left_reg : prev_right_reg;

    always_comb
    begin
        job.a_left    = prev_left_reg;
        job.a_right   = prv_right;
        job.d_left    = DIFF_W'(left_in) - DIFF_W'(prev_left_reg);
        job.d_right   = DIFF_W'(cur_right) - DIFF_W'(prv_right);
        job.c_left    = left_in;
        job.c_right   = cur_right;
        job.do_interp = prev_valid_reg;
        job.is_end    = stream_end;
    end

    // a first frame that does not end the stream is only stored
    assign q_push = in_xfer && (prev_valid_reg || stream_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            prev_valid_reg <= !stream_end;
        end
    end

    // store the raw right sample; mono is applied when a job is built
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            prev_left_reg  <= left_in;
            prev_right_reg <= right_in;
        end
    end

endmodule

>>> rtl/rsmp_job_queue.sv
`timescale 1ns / 1ps

module rsmp_job_queue
    import rsmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rsmp_job_t          push_job,
    input  logic               pop,
    output rsmp_job_t          pop_job,
    output rsmp_queue_status_t status
);

    rsmp_job_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/rsmp_back.sv
`timescale 1ns / 1ps

module rsmp_back
    import rsmp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rsmp_queue_status_t         q_status,
    input  rsmp_job_t                  job,
    output logic                       q_pop,
    input  logic [STEP_W-1:0]          phase_step,
    input  logic [GAIN_W-1:0]          gain,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       has_sample,
    output logic                       end_of_stream
);

    localparam logic signed [MUL2_W-1:0] SAT_MAX = MUL2_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [MUL2_W-1:0] SAT_MIN = -MUL2_W'(1 << (SAMPLE_W - 1));

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [MUL2_W-1:0] prod
    );
        logic signed [MUL2_W-1:0] v;
        v = prod >>> GAIN_SHIFT;
        if (v > SAT_MAX)
            return SAT_MAX[SAMPLE_W-1:0];
        else if (v < SAT_MIN)
            return SAT_MIN[SAMPLE_W-1:0];
        else
            return v[SAMPLE_W-1:0];
    endfunction

    rsmp_back_state_t state_reg;
    rsmp_back_state_t state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               emitted_reg;
    logic               emitted_next;
    rsmp_job_t          job_reg;

    logic [STEP_W-1:0]  step;
    logic [SUM_W-1:0]   phase_ext;
    logic [SUM_W-1:0]   phase_adv;
    logic               below_one;

    // issue into the arithmetic pipeline
    logic                        iss_valid;
    logic signed [SAMPLE_W-1:0]  iss_a_left;
    logic signed [SAMPLE_W-1:0]  iss_a_right;
    logic signed [DIFF_W-1:0]    iss_d_left;
    logic signed [DIFF_W-1:0]    iss_d_right;
    logic [PHASE_FRAC_BITS-1:0]  iss_frac;
    logic                        iss_has;
    logic                        iss_end;

    logic signed [MUL1_W-1:0]    mul1_left;
    logic signed [MUL1_W-1:0]    mul1_right;
    logic signed [DIFF_W-1:0]    interp_left;
    logic signed [DIFF_W-1:0]    interp_right;
    logic signed [MUL2_W-1:0]    mul2_left;
    logic signed [MUL2_W-1:0]    mul2_right;

    logic                        s1_valid_reg;
    logic signed [SAMPLE_W-1:0]  s1_a_left_reg;
    logic signed [SAMPLE_W-1:0]  s1_a_right_reg;
    logic signed [MUL1_W-1:0]    s1_prod_left_reg;
    logic signed [MUL1_W-1:0]    s1_prod_right_reg;
    logic                        s1_has_reg;
    logic                        s1_end_reg;

    logic                        s2_valid_reg;
    logic signed [MUL2_W-1:0]    s2_prod_left_reg;
    logic signed [MUL2_W-1:0]    s2_prod_right_reg;
    logic                        s2_has_reg;
    logic                        s2_end_reg;

    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  left_out_reg;
    logic signed [SAMPLE_W-1:0]  right_out_reg;
    logic                        has_sample_reg;
    logic                        end_of_stream_reg;

    logic en_out;
    logic en_s2;
    logic en_s1;

    assign en_out = !out_valid_reg || out_ready;
    assign en_s2  = !s2_valid_reg || en_out;
    assign en_s1  = !s1_valid_reg || en_s2;

    assign step      = (phase_step < MIN_STEP) ? MIN_STEP : phase_step;
    assign phase_ext = SUM_W'(phase_reg);
    assign phase_adv = phase_ext + SUM_W'(step);
    assign below_one = phase_ext < ONE_PHASE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                    state_next = job.do_interp ? BK_INTERP : BK_HOLD;
            end
            BK_INTERP:
            begin
                if (!below_one)
                    state_next = job_reg.is_end ? BK_HOLD : BK_IDLE;
            end
            BK_HOLD:
            begin
                if (!below_one && (emitted_reg || en_s1))
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        phase_next   = phase_reg;
        emitted_next = emitted_reg;
        iss_valid    = 1'b0;
        iss_a_left   = '0;
        iss_a_right  = '0;
        iss_d_left   = '0;
        iss_d_right  = '0;
        iss_frac     = phase_reg[PHASE_FRAC_BITS-1:0];
        iss_has      = 1'b0;
        iss_end      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_status.empty;
                if (!q_status.empty)
                    emitted_next = 1'b0;
            end
            BK_INTERP:
            begin
                if (below_one)
                begin
                    if (en_s1)
                    begin
                        iss_valid    = 1'b1;
                        iss_a_left   = job_reg.a_left;
                        iss_a_right  = job_reg.a_right;
                        iss_d_left   = job_reg.d_left;
                        iss_d_right  = job_reg.d_right;
                        iss_has      = 1'b1;
                        // mark end here when the hold span that follows is empty
                        iss_end      = job_reg.is_end && (phase_adv >= TWO_PHASE);
                        phase_next   = phase_adv[PHASE_W-1:0];
                        emitted_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PHASE_W'(phase_ext - ONE_PHASE);
                end
            end
            BK_HOLD:
            begin
                if (below_one)
                begin
                    if (en_s1)
                    begin
                        iss_valid    = 1'b1;
                        iss_a_left   = job_reg.c_left;
                        iss_a_right  = job_reg.c_right;
                        iss_has      = 1'b1;
                        iss_end      = (phase_adv >= ONE_PHASE);
                        phase_next   = phase_adv[PHASE_W-1:0];
                        emitted_next = 1'b1;
                    end
                end
                else if (emitted_reg)
                begin
                    phase_next = '0;
                end
                else if (en_s1)
                begin
                    // nothing carried the end mark: send a sampleless result
                    iss_valid  = 1'b1;
                    iss_end    = 1'b1;
                    phase_next = '0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            phase_reg   <= '0;
            emitted_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= job;
    end

    assign mul1_left  = MUL1_W'(iss_d_left) * MUL1_W'($signed({1'b0, iss_frac}));
    assign mul1_right = MUL1_W'(iss_d_right) * MUL1_W'($signed({1'b0, iss_frac}));

    assign interp_left  = DIFF_W'(s1_a_left_reg) + DIFF_W'(s1_prod_left_reg >>> PHASE_FRAC_BITS);
    assign interp_right = DIFF_W'(s1_a_right_reg) + DIFF_W'(s1_prod_right_reg >>> PHASE_FRAC_BITS);

    assign mul2_left  = MUL2_W'(interp_left) * MUL2_W'($signed({1'b0, gain}));
    assign mul2_right = MUL2_W'(interp_right) * MUL2_W'($signed({1'b0, gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
                s1_valid_reg <= iss_valid;
            if (en_s2)
                s2_valid_reg <= s1_valid_reg;
            if (en_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            s1_a_left_reg     <= iss_a_left;
            s1_a_right_reg    <= iss_a_right;
            s1_prod_left_reg  <= mul1_left;
            s1_prod_right_reg <= mul1_right;
            s1_has_reg        <= iss_has;
            s1_end_reg        <= iss_end;
        end
        if (en_s2)
        begin
            s2_prod_left_reg  <= mul2_left;
            s2_prod_right_reg <= mul2_right;
            s2_has_reg        <= s1_has_reg;
            s2_end_reg        <= s1_end_reg;
        end
        if (en_out)
        begin
            left_out_reg      <= sat_sample(s2_prod_left_reg);
            right_out_reg     <= sat_sample(s2_prod_right_reg);
            has_sample_reg    <= s2_has_reg;
            end_of_stream_reg <= s2_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_out      = left_out_reg;
    assign right_out     = right_out_reg;
    assign has_sample    = has_sample_reg;
    assign end_of_stream = end_of_stream_reg;

endmodule

>>> rtl/linear_interp_audio_resampler_core.sv
`timescale 1ns / 1ps

// channel   signals                                        direction
// input     in_valid/in_ready, left_in, right_in, stream_end   in
// output    out_valid/out_ready, left_out, right_out,          out
//           has_sample, end_of_stream
// config    cfg_valid/cfg_ready, cfg_index, cfg_data           in
//
// The idle state dequeues an item; the phase sequencer then issues its results as
// the pipeline takes them and closes each span (interpolation and, on stream end,
// hold) in its own step. Results cross the two-multiplier s1/s2/output registers.
// Reset clears the held-frame flag, the phase, the job queue and all valids;
// configuration returns to step 1.0, unity gain, stereo. cfg_ready is always high.
// A stalled output freezes the pipeline and halts issue by the sequencer; the front
// keeps taking frames until the two-entry job queue is full.

module linear_interp_audio_resampler_core
    import rsmp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] left_in,
    input  logic signed [SAMPLE_W-1:0] right_in,
    input  logic                       stream_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] left_out,
    output logic signed [SAMPLE_W-1:0] right_out,
    output logic                       has_sample,
    output logic                       end_of_stream,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    rsmp_cfg_t          cfg_reg;
    rsmp_queue_status_t q_status;
    rsmp_job_t          push_job;
    rsmp_job_t          pop_job;
    logic               q_push;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= PHASE_STEP_RESET;
            cfg_reg.gain       <= GAIN_RESET;
            cfg_reg.mono       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: cfg_reg.phase_step <= cfg_data[STEP_W-1:0];
                CFG_GAIN:       cfg_reg.gain       <= cfg_data[GAIN_W-1:0];
                CFG_MONO:       cfg_reg.mono       <= cfg_data[0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    rsmp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .left_in    (left_in),
        .right_in   (right_in),
        .stream_end (stream_end),
        .mono       (cfg_reg.mono),
        .q_status   (q_status),
        .q_push     (q_push),
        .job        (push_job)
    );

    rsmp_job_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    rsmp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .job           (pop_job),
        .q_pop         (q_pop),
        .phase_step    (cfg_reg.phase_step),
        .gain          (cfg_reg.gain),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .has_sample    (has_sample),
        .end_of_stream (end_of_stream)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("job popped from an empty queue");

    a_sampleless_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_sample) |-> (end_of_stream && left_out == '0 && right_out == '0))
        else $error("sampleless result without end mark or with data");

endmodule
